// ----- rtl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared codes, widths and the sweep/write structs of the task table chain.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int unsigned DEFAULT_MAX_ENTRIES = 16;
   localparam int unsigned SLOT_W = 8;   // covers up to 256 entries

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CHOOSE = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // Token that walks the chain, one cell per cycle.
   typedef struct packed {
      logic              valid;
      logic [15:0]       key;
      logic [31:0]       t;
      logic              any;
      logic [31:0]       earliest;
      logic              match;
      logic [SLOT_W-1:0] match_slot;
      logic              free;
      logic [SLOT_W-1:0] free_slot;
      logic              pick;
      logic [30:0]       pick_rem;
      logic [15:0]       pick_id;
   } sweep_type;

   // Broadcast table write.
   typedef struct packed {
      logic              en;
      logic              set;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       id;
      logic [31:0]       arrival;
      logic [30:0]       remaining;
   } wr_type;

endpackage

// ----- rtl/srtf_cell.sv -----
// ----------------------------------------------------------------------------
// srtf_cell
// One table entry; folds its entry into the passing sweep and registers it.
// ----------------------------------------------------------------------------
module srtf_cell
   import srtf_pkg::*;
#(
   parameter int unsigned IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  sweep_type sweep_i,
   input  wr_type    wr_i,
   output sweep_type sweep_o
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

   logic        valid_ff;
   logic [15:0] id_ff;
   logic [31:0] arr_ff;
   logic [30:0] rem_ff;
   sweep_type   sweep_ff, sweep_in;

   always_comb begin
      sweep_in = sweep_i;
      if (valid_ff) begin
         sweep_in.any = 1'b1;
         if (!sweep_i.any || arr_ff < sweep_i.earliest) begin
            sweep_in.earliest = arr_ff;
         end
         if (!sweep_i.match && id_ff == sweep_i.key) begin
            sweep_in.match      = 1'b1;
            sweep_in.match_slot = MY_SLOT;
         end
         if (arr_ff <= sweep_i.t && (!sweep_i.pick || rem_ff < sweep_i.pick_rem ||
             (rem_ff == sweep_i.pick_rem && id_ff < sweep_i.pick_id))) begin
            sweep_in.pick     = 1'b1;
            sweep_in.pick_rem = rem_ff;
            sweep_in.pick_id  = id_ff;
         end
      end else if (!sweep_i.free) begin
         sweep_in.free      = 1'b1;
         sweep_in.free_slot = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         if (wr_i.en && wr_i.slot == MY_SLOT) begin
            valid_ff <= wr_i.set;
         end
      end
      if (wr_i.en && wr_i.set && wr_i.slot == MY_SLOT) begin
         id_ff  <= wr_i.id;
         arr_ff <= wr_i.arrival;
         rem_ff <= wr_i.remaining;
      end
   end

   assign sweep_o = sweep_ff;

endmodule

// ----- rtl/srtf_ready_selector_unit.sv -----
// ----------------------------------------------------------------------------
// srtf_ready_selector_unit
// Shortest-remaining-time-first task table built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (add/update, choose, remove) and each
// produces exactly one transfer on the rsp_ channel (status, chosen id,
// effective time). Both channels use valid/ready.
// One request is in flight at a time. A request launches a sweep token into
// the cell chain; it passes one cell per cycle. Add, remove and a choose that
// finds a ready task finish after one scan; a choose with nothing arrived by
// now runs a second scan at the earliest arrival. Table writes are broadcast
// after the first scan. Reset clears every entry valid bit and the control
// state; no clearing pass is needed. If the receiver stalls, the finished
// result holds in the output register and the next request may be taken;
// its result waits until the output register is free.
// ----------------------------------------------------------------------------
module srtf_ready_selector_unit
   import srtf_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_task_id,
   input  logic [31:0] req_arrival_time,
   input  logic [30:0] req_remaining_time,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_chosen_id,
   output logic [31:0] rsp_effective_time
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN1, S_SCAN2, S_FINISH} state_type;

   state_type   state_ff;
   logic [1:0]  op_ff;
   logic [15:0] id_ff;
   logic [31:0] arr_ff;
   logic [30:0] rem_ff;
   logic [1:0]  res_status_ff;
   logic [15:0] res_id_ff;
   logic [31:0] res_eff_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_id_ff;
   logic [31:0] rsp_eff_ff;

   sweep_type chain [MAX_ENTRIES+1];
   sweep_type launch;
   wr_type    wr;
   sweep_type tail;

   assign tail = chain[MAX_ENTRIES];

   genvar g;
   generate
      for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
         srtf_cell #(.IDX(g)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .sweep_i (chain[g]),
            .wr_i    (wr),
            .sweep_o (chain[g+1])
         );
      end
   endgenerate

   assign req_ready = (state_ff == S_IDLE);
   wire accept = req_valid && req_ready;

   always_comb begin
      launch = '0;
      if (accept) begin
         launch.valid = 1'b1;
         launch.key   = req_task_id;
         launch.t     = req_now;
      end else if (state_ff == S_SCAN1 && tail.valid && op_ff == REQ_CHOOSE &&
                   tail.any && !tail.pick) begin
         // nothing arrived yet: rescan at the earliest arrival
         launch.valid = 1'b1;
         launch.t     = tail.earliest;
      end
   end
   assign chain[0] = launch;

   always_comb begin
      wr           = '0;
      wr.id        = id_ff;
      wr.arrival   = arr_ff;
      wr.remaining = rem_ff;
      if (state_ff == S_SCAN1 && tail.valid) begin
         if (op_ff == REQ_ADD && (tail.match || tail.free)) begin
            wr.en   = 1'b1;
            wr.set  = 1'b1;
            wr.slot = tail.match ? tail.match_slot : tail.free_slot;
         end else if (op_ff == REQ_REMOVE && tail.match) begin
            wr.en   = 1'b1;
            wr.slot = tail.match_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a finishing request reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_type;
                  id_ff    <= req_task_id;
                  arr_ff   <= req_arrival_time;
                  rem_ff   <= req_remaining_time;
                  state_ff <= S_SCAN1;
               end
            end
            S_SCAN1: begin
               if (tail.valid) begin
                  res_status_ff <= ST_OK;
                  res_id_ff     <= '0;
                  res_eff_ff    <= '0;
                  state_ff      <= S_FINISH;
                  case (op_ff)
                     REQ_ADD: begin
                        if (!tail.match && !tail.free) res_status_ff <= ST_FULL;
                     end
                     REQ_REMOVE: begin
                        if (!tail.match) res_status_ff <= ST_NOT_FOUND;
                     end
                     REQ_CHOOSE: begin
                        if (!tail.any) begin
                           res_status_ff <= ST_EMPTY;
                        end else if (tail.pick) begin
                           res_id_ff  <= tail.pick_id;
                           res_eff_ff <= tail.t;
                        end else begin
                           state_ff <= S_SCAN2;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN2: begin
               if (tail.valid) begin
                  res_status_ff <= tail.pick ? ST_OK : ST_EMPTY;
                  res_id_ff     <= tail.pick ? tail.pick_id : 16'd0;
                  res_eff_ff    <= tail.pick ? tail.t : 32'd0;
                  state_ff      <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_id_ff     <= res_id_ff;
                  rsp_eff_ff    <= res_eff_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_id      = rsp_id_ff;
   assign rsp_effective_time = rsp_eff_ff;

   a_tail_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == S_SCAN1 || state_ff == S_SCAN2))
      else $error("sweep left chain outside a scan");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (32'(wr.slot) < MAX_ENTRIES))
      else $error("table write beyond last entry");

   a_scan2_from_choose: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN2) |-> (op_ff == REQ_CHOOSE))
      else $error("second scan for a non-choose request");

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not moved to output");

endmodule
